[design/sfir_pkg.sv]
`default_nettype none

package sfir_pkg;

  // field widths
  localparam int DATA_W    = 16;
  localparam int COEF_W    = 16;
  localparam int FRAC_W    = 14;
  localparam int NUM_COEFS = 5;
  localparam int TAPS_DEF  = 9;
  localparam int CFG_IDX_W = 3;

  typedef logic [DATA_W-1:0] sample_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef coef_t [NUM_COEFS-1:0] coef_arr_t;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_TAP3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 3'd4;

  // coefficient reset values, outer tap to center
  localparam coef_t COEF_RST_TAP0   = 16'd1210;
  localparam coef_t COEF_RST_TAP1   = 16'd1372;
  localparam coef_t COEF_RST_TAP2   = 16'd1495;
  localparam coef_t COEF_RST_TAP3   = 16'd1572;
  localparam coef_t COEF_RST_CENTER = 16'd5086;

  // saturation limits
  localparam sample_t SAT_MAX = 16'h7fff;
  localparam sample_t SAT_MIN = 16'h8000;

  // controls for the tap shift registers
  typedef struct packed {
    logic load;
    logic rotate;
  } tap_ctrl_t;

  // controls for the column sum and accumulator
  typedef struct packed {
    logic clear;
    logic run;
    logic sign_bit;
  } acc_ctrl_t;

endpackage

`default_nettype wire

[design/sfir_if.sv]
`default_nettype none

// sample channel
interface sfir_in_if;
  import sfir_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;
  logic    block_end;

  modport source (output valid, output sample, output block_end, input ready);
  modport sink   (input valid, input sample, input block_end, output ready);
endinterface

// result channel
interface sfir_out_if;
  import sfir_pkg::*;

  logic    valid;
  logic    ready;
  sample_t filtered_sample;
  logic    block_end_out;

  modport source (output valid, output filtered_sample, output block_end_out, input ready);
  modport sink   (input valid, input filtered_sample, input block_end_out, output ready);
endinterface

`default_nettype wire

[design/sfir_tap_line.sv]
`default_nettype none

module sfir_tap_line #(
  parameter int TAPS = sfir_pkg::TAPS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sfir_pkg::tap_ctrl_t ctrl_i,
  input  wire sfir_pkg::sample_t  sample_i,
  output logic [TAPS-1:0]         bits_o
);
  import sfir_pkg::*;

  sample_t taps_q [TAPS];

  // delay line of shift registers; a full rotation restores every sample
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < TAPS; k++) begin
        taps_q[k] <= '0;
      end
    end else if (ctrl_i.load) begin
      taps_q[0] <= sample_i;
      for (int k = 1; k < TAPS; k++) begin
        taps_q[k] <= taps_q[k-1];
      end
    end else if (ctrl_i.rotate) begin
      for (int k = 0; k < TAPS; k++) begin
        taps_q[k] <= {taps_q[k][DATA_W-2:0], taps_q[k][DATA_W-1]};
      end
    end
  end

  // current bit of each tap, msb first
  always_comb begin
    for (int k = 0; k < TAPS; k++) begin
      bits_o[k] = taps_q[k][DATA_W-1];
    end
  end

endmodule

`default_nettype wire

[design/sfir_acc.sv]
`default_nettype none

module sfir_acc #(
  parameter int TAPS = sfir_pkg::TAPS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire sfir_pkg::acc_ctrl_t ctrl_i,
  input  wire logic [TAPS-1:0]     bits_i,
  input  wire sfir_pkg::coef_arr_t coefs_i,
  output sfir_pkg::sample_t        result_o
);
  import sfir_pkg::*;

  localparam int COL_W  = COEF_W + $clog2(TAPS);
  localparam int ACC_W  = COL_W + DATA_W;
  localparam int Q_W    = ACC_W - FRAC_W;
  localparam int HI_W   = Q_W - DATA_W + 1;
  localparam int CENTER = (TAPS - 1) / 2;

  // register chosen by distance from the center tap
  function automatic int coef_index(input int k);
    int d;
    d = (k > CENTER) ? (k - CENTER) : (CENTER - k);
    if (d > NUM_COEFS - 1) begin
      d = NUM_COEFS - 1;
    end
    return NUM_COEFS - 1 - d;
  endfunction

  logic [COL_W-1:0] terms [TAPS];
  logic [COL_W-1:0] col_sum;
  logic [COL_W-1:0] col_q;
  logic             col_vld_q;
  logic             col_neg_q;
  logic [ACC_W-1:0] acc_q;
  logic [ACC_W-1:0] acc_d;
  logic [ACC_W-1:0] col_ext;
  logic [ACC_W-1:0] rnd;
  logic [Q_W-1:0]   q;
  logic [HI_W-1:0]  q_hi;

  // gated coefficient per tap, sign extended
  for (genvar k = 0; k < TAPS; k++) begin : g_term
    localparam int CI = coef_index(k);
    assign terms[k] = bits_i[k]
        ? {{(COL_W-COEF_W){coefs_i[CI][COEF_W-1]}}, coefs_i[CI]}
        : '0;
  end

  // column sum over the taps for one bit position
  always_comb begin
    col_sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      col_sum = col_sum + terms[k];
    end
  end

  // column register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vld_q <= 1'b0;
      col_neg_q <= 1'b0;
    end else begin
      col_vld_q <= ctrl_i.run;
      col_neg_q <= ctrl_i.sign_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.run) begin
      col_q <= col_sum;
    end
  end

  // horner accumulation, sign bit column carries negative weight
  always_comb begin
    col_ext = {{(ACC_W-COL_W){col_q[COL_W-1]}}, col_q};
    acc_d   = {acc_q[ACC_W-2:0], 1'b0} + (col_neg_q ? (~col_ext + 1'b1) : col_ext);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (col_vld_q) begin
      acc_q <= acc_d;
    end
  end

  // round half up to q1.15 and saturate
  always_comb begin
    rnd  = acc_q + (ACC_W'(1) << (FRAC_W - 1));
    q    = rnd[ACC_W-1:FRAC_W];
    q_hi = q[Q_W-1:DATA_W-1];
    if ((&q_hi) || !(|q_hi)) begin
      result_o = q[DATA_W-1:0];
    end else if (q[Q_W-1]) begin
      result_o = SAT_MIN;
    end else begin
      result_o = SAT_MAX;
    end
  end

endmodule

`default_nettype wire

[design/symmetric_fir_filter.sv]
// symmetric fir filter, bit-serial multiply-accumulate over the delay line
// sequence: an input transfer loads the delay line, the msb-first tap walk runs
// in S_RUN, S_FLUSH accumulates the last column and S_DONE moves the result into
// the output register once it is free; a new sample is taken only in S_IDLE
// reset: delay line cleared to zero, coefficients to their default values,
// no result pending
`default_nettype none

module symmetric_fir_filter #(
  parameter int TAPS = sfir_pkg::TAPS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  sfir_in_if.sink                                in_i,
  sfir_out_if.source                             out_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [sfir_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [sfir_pkg::COEF_W-1:0]       cfg_data_i
);
  import sfir_pkg::*;

  localparam int CNT_W = $clog2(DATA_W);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e     state_q, state_d;
  logic [CNT_W-1:0] cnt_q;
  coef_arr_t  coef_q;
  logic       be_q;
  logic       out_valid_q;
  sample_t    out_sample_q;
  logic       out_be_q;
  logic       in_xfer;
  logic       out_free;
  logic [TAPS-1:0] tap_bits;
  sample_t    result;
  tap_ctrl_t  tap_ctrl;
  acc_ctrl_t  acc_ctrl;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;

  // coefficient registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[REG_COEF_TAP0]   <= COEF_RST_TAP0;
      coef_q[REG_COEF_TAP1]   <= COEF_RST_TAP1;
      coef_q[REG_COEF_TAP2]   <= COEF_RST_TAP2;
      coef_q[REG_COEF_TAP3]   <= COEF_RST_TAP3;
      coef_q[REG_COEF_CENTER] <= COEF_RST_CENTER;
    end else if (cfg_we_i && (cfg_idx_i <= REG_COEF_CENTER)) begin
      coef_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = S_RUN;
      end
      S_RUN: begin
        if (cnt_q == CNT_W'(DATA_W - 1)) state_d = S_FLUSH;
      end
      S_FLUSH: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_RUN) begin
        cnt_q <= cnt_q + 1'b1;
      end else begin
        cnt_q <= '0;
      end
    end
  end

  // block end flag rides along with the item
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      be_q <= in_i.block_end;
    end
  end

  // datapath controls
  always_comb begin
    tap_ctrl.load     = in_xfer;
    tap_ctrl.rotate   = (state_q == S_RUN);
    acc_ctrl.clear    = in_xfer;
    acc_ctrl.run      = (state_q == S_RUN);
    acc_ctrl.sign_bit = (cnt_q == '0);
  end

  sfir_tap_line #(
    .TAPS (TAPS)
  ) u_tap_line (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (tap_ctrl),
    .sample_i (in_i.sample),
    .bits_o   (tap_bits)
  );

  sfir_acc #(
    .TAPS (TAPS)
  ) u_acc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (acc_ctrl),
    .bits_i   (tap_bits),
    .coefs_i  (coef_q),
    .result_o (result)
  );

  // output register, holds a result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == S_DONE) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_DONE) && out_free) begin
      out_sample_q <= result;
      out_be_q     <= be_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = out_sample_q;
  assign out_o.block_end_out   = out_be_q;

endmodule

`default_nettype wire
